@@ sv/llf_pkg.sv @@
// Shared types and constants of the least-laxity-first scheduler.
// Holds the item layouts, the task record kept in memory and the scan control structs.
// Depends on nothing; the interfaces, the scan engine, the scheduler and the checker import it.
package llf_pkg;

  localparam int unsigned MAX_TASKS_DEF = 8;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned IDENT_W       = 16;
  localparam int unsigned WORK_W        = 16;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned LAX_W         = TIME_W + 2;

  localparam logic [COUNT_W-1:0] TASK_COUNT_RST = COUNT_W'(1);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic                func;
    logic [SLOT_W-1:0]   slot;
    logic [IDENT_W-1:0]  task_ident;
    logic [WORK_W-1:0]   task_period;
    logic [WORK_W-1:0]   task_burst;
  } in_item_t;

  typedef struct packed {
    logic                ran_valid;
    logic [SLOT_W-1:0]   ran_slot;
    logic [IDENT_W-1:0]  ran_ident;
    logic [WORK_W-1:0]   work_left;
    logic                job_released;
    logic [TIME_W-1:0]   next_arrival;
    logic                finished;
    logic [TIME_W-1:0]   tick_now;
  } out_item_t;

  typedef struct packed {
    logic [IDENT_W-1:0]  ident;
    logic [WORK_W-1:0]   period;
    logic [WORK_W-1:0]   burst;
    logic [TIME_W-1:0]   arrival;
    logic [TIME_W-1:0]   deadline;
    logic [WORK_W-1:0]   remaining;
  } task_rec_t;

  localparam int unsigned REC_W = $bits(task_rec_t);

  typedef struct packed {
    logic               start;
    logic               ref_mode;
    logic [TIME_W-1:0]  now;
  } scan_cmd_t;

  typedef struct packed {
    logic       done;
    task_rec_t  best_rec;
    task_rec_t  last_rec;
  } scan_res_t;

endpackage

@@ sv/llf_if.sv @@
// Valid/ready channel interfaces for the scheduler's input and result items.
// Depends on llf_pkg for the payload types.
interface llf_in_if;
  import llf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface llf_out_if;
  import llf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/llf_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module llf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/llf_scan.sv @@
// Laxity scan engine: walks the task memory one entry a cycle and keeps the best candidate.
// Reference mode finds the largest positive initial laxity; pick mode finds the least laxity.
// Depends on llf_pkg and on the read port of the task memory.
module llf_scan #(
  parameter int unsigned MAX_TASKS = llf_pkg::MAX_TASKS_DEF,
  localparam int unsigned AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  llf_pkg::scan_cmd_t  cmd_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [AW-1:0]       ref_idx_i,
  input  logic [AW-1:0]       last_idx_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  llf_pkg::task_rec_t  rd_data_i,
  output llf_pkg::scan_res_t  res_o,
  output logic [AW-1:0]       best_idx_o
);
  import llf_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_TASKS + 3);

  typedef enum logic [1:0] {
    KIND_REF,
    KIND_SEED,
    KIND_SCAN,
    KIND_LAST
  } kind_e;

  logic                    busy_q, iss_q, mode_q, done_q;
  logic [POS_W-1:0]        pos_q, last_pos_q;
  logic [POS_W-1:0]        len;
  kind_e                   kind;
  logic [AW-1:0]           addr;

  logic                    s1_v_q;
  kind_e                   s1_kind_q;
  logic [AW-1:0]           s1_idx_q;

  logic                    s2_v_q;
  kind_e                   s2_kind_q;
  logic [AW-1:0]           s2_idx_q;
  logic signed [LAX_W-1:0] s2_lax_q;
  logic                    s2_arr_q;
  task_rec_t               s2_rec_q;

  logic signed [LAX_W-1:0] best_lax_q;
  logic [AW-1:0]           best_idx_q;
  task_rec_t               best_rec_q;
  task_rec_t               last_rec_q;

  logic [TIME_W-1:0]       diff_dl, diff_arr;
  logic [WORK_W-1:0]       work;
  logic signed [LAX_W-1:0] lax;

  assign len = cmd_i.ref_mode ? POS_W'(count_i) : POS_W'(count_i) + POS_W'(2);

  // The pick sequence is the reference entry, then every active slot, then the last run slot.
  always_comb begin
    if (mode_q) begin
      addr = AW'(pos_q);
      kind = KIND_REF;
    end else if (pos_q == '0) begin
      addr = ref_idx_i;
      kind = KIND_SEED;
    end else if (pos_q == last_pos_q) begin
      addr = last_idx_i;
      kind = KIND_LAST;
    end else begin
      addr = AW'(pos_q - POS_W'(1));
      kind = KIND_SCAN;
    end
  end

  always_comb begin
    diff_dl  = rd_data_i.deadline - cmd_i.now;
    diff_arr = cmd_i.now - rd_data_i.arrival;
    work     = (s1_kind_q == KIND_REF) ? rd_data_i.burst : rd_data_i.remaining;
    lax      = $signed({{2{diff_dl[TIME_W-1]}}, diff_dl})
             - $signed({{(LAX_W - WORK_W){1'b0}}, work});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_q      <= 1'b0;
      mode_q     <= 1'b0;
      done_q     <= 1'b0;
      pos_q      <= '0;
      last_pos_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      s1_v_q <= iss_q;
      s2_v_q <= s1_v_q;
      if (cmd_i.start) begin
        busy_q     <= 1'b1;
        iss_q      <= (len != '0);
        mode_q     <= cmd_i.ref_mode;
        pos_q      <= '0;
        last_pos_q <= len - POS_W'(1);
      end else if (iss_q) begin
        pos_q <= pos_q + POS_W'(1);
        if (pos_q == last_pos_q) begin
          iss_q <= 1'b0;
        end
      end else if (busy_q && !s1_v_q && !s2_v_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= kind;
    s1_idx_q  <= addr;
    s2_kind_q <= s1_kind_q;
    s2_idx_q  <= s1_idx_q;
    s2_lax_q  <= lax;
    s2_arr_q  <= ~diff_arr[TIME_W-1];
    s2_rec_q  <= rd_data_i;
    if (cmd_i.start) begin
      best_lax_q <= '0;
      best_idx_q <= '0;
    end else if (s2_v_q) begin
      unique case (s2_kind_q)
        KIND_REF: begin
          if (s2_lax_q > best_lax_q) begin
            best_lax_q <= s2_lax_q;
            best_idx_q <= s2_idx_q;
          end
        end
        KIND_SEED: begin
          best_lax_q <= s2_lax_q;
          best_idx_q <= s2_idx_q;
          best_rec_q <= s2_rec_q;
        end
        KIND_SCAN: begin
          if (s2_arr_q && (s2_lax_q < best_lax_q)) begin
            best_lax_q <= s2_lax_q;
            best_idx_q <= s2_idx_q;
            best_rec_q <= s2_rec_q;
          end
        end
        KIND_LAST: begin
          last_rec_q <= s2_rec_q;
        end
      endcase
    end
  end

  assign rd_en_o        = iss_q;
  assign rd_addr_o      = addr;
  assign res_o.done     = done_q;
  assign res_o.best_rec = best_rec_q;
  assign res_o.last_rec = last_rec_q;
  assign best_idx_o     = best_idx_q;

endmodule

@@ sv/least_laxity_first_scheduler.sv @@
// Least-laxity-first scheduler for periodic tasks, counted in integer ticks.
// Input channel in_i: a load transfer writes one task slot (identifier, period, burst);
// a tick transfer runs one tick of the arrived task with the least laxity.
// Output channel out_o: exactly one result transfer per input transfer, in order.
// The configuration write port sets the number of active slots; write it only while idle.
// Task records live in one memory with a registered read port. A tick reads every active
// slot through the scan engine, one entry a cycle, then writes the chosen record back.
// A load returns its result without a scan; a tick reads all N active slots through the one
// memory read port, and the first tick adds a reference scan over the slots to fix the
// reference task. A tick after scheduling has finished returns its result without a scan.
// One item is processed at a time; in_i.ready is high while the block is idle, and a new item
// is taken while the previous result still waits in the output register.
// If the receiver stalls, a finished result waits until the output register is free.
// Reset clears time, the reference and last slots, the started and stopped flags, and sets
// the slot count to one; the task memory holds no defined contents until loaded.
module least_laxity_first_scheduler #(
  parameter int unsigned MAX_TASKS = llf_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  llf_in_if.sink                        in_i,
  llf_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [llf_pkg::COUNT_W-1:0]   cfg_wdata_i
);
  import llf_pkg::*;

  localparam int unsigned AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REF,
    S_PICK,
    S_UPDATE,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] task_count_q;
  logic [TIME_W-1:0]  tick_q;
  logic [AW-1:0]      last_q, ref_q, sel_idx_q;
  logic               started_q, stopped_q, start_q, ref_mode_q, out_valid_q;
  out_item_t          res_q, out_q;
  task_rec_t          sel_rec_q;

  logic [CNT_W-1:0]   n_act;
  logic               in_xfer, slot_ok;
  task_rec_t          load_rec, upd_rec;
  out_item_t          idle_res, upd_res;

  scan_cmd_t          scan_cmd;
  scan_res_t          scan_res;
  logic [AW-1:0]      best_idx;
  logic               rd_en, ram_we;
  logic [AW-1:0]      rd_addr, ram_waddr;
  task_rec_t          rd_data, ram_wdata;

  logic [TIME_W-1:0]  since_last, key_last, key_best;
  logic               keep_last;
  logic [WORK_W-1:0]  rem_dec;
  logic               job_done, stop_now;

  assign n_act   = (32'(task_count_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_q);
  assign in_xfer = in_i.valid && in_i.ready;
  assign slot_ok = 32'(in_i.payload.slot) < MAX_TASKS;

  always_comb begin
    load_rec.ident     = in_i.payload.task_ident;
    load_rec.period    = in_i.payload.task_period;
    load_rec.burst     = in_i.payload.task_burst;
    load_rec.arrival   = '0;
    load_rec.deadline  = TIME_W'(in_i.payload.task_period);
    load_rec.remaining = in_i.payload.task_burst;

    idle_res           = '0;
    idle_res.finished  = stopped_q;
    idle_res.tick_now  = tick_q;
  end

  // The last run task keeps the processor when it has waited and ties on deadline minus work.
  always_comb begin
    since_last = tick_q - scan_res.last_rec.arrival;
    key_last   = scan_res.last_rec.deadline - TIME_W'(scan_res.last_rec.remaining);
    key_best   = scan_res.best_rec.deadline - TIME_W'(scan_res.best_rec.remaining);
    keep_last  = (best_idx != last_q) && !since_last[TIME_W-1] && (since_last != '0)
               && (key_last == key_best);
  end

  always_comb begin
    rem_dec  = (sel_rec_q.remaining != '0) ? sel_rec_q.remaining - WORK_W'(1) : '0;
    job_done = (rem_dec == '0);
    stop_now = job_done && (sel_idx_q == ref_q);

    upd_rec           = sel_rec_q;
    upd_rec.remaining = rem_dec;
    if (job_done && !stop_now) begin
      upd_rec.arrival   = sel_rec_q.arrival + TIME_W'(sel_rec_q.period);
      upd_rec.deadline  = sel_rec_q.deadline + TIME_W'(sel_rec_q.period);
      upd_rec.remaining = sel_rec_q.burst;
    end

    upd_res              = '0;
    upd_res.ran_valid    = 1'b1;
    upd_res.ran_slot     = SLOT_W'(sel_idx_q);
    upd_res.ran_ident    = sel_rec_q.ident;
    upd_res.work_left    = rem_dec;
    upd_res.job_released = job_done && !stop_now;
    upd_res.next_arrival = (job_done && !stop_now) ? upd_rec.arrival : '0;
    upd_res.finished     = stop_now;
    upd_res.tick_now     = tick_q;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(in_i.payload.slot);
    ram_wdata = load_rec;
    if (state_q == S_UPDATE) begin
      ram_we    = 1'b1;
      ram_waddr = sel_idx_q;
      ram_wdata = upd_rec;
    end else if ((state_q == S_IDLE) && in_xfer && (in_i.payload.func == FUNC_LOAD) && slot_ok) begin
      ram_we = 1'b1;
    end
  end

  assign scan_cmd.start    = start_q;
  assign scan_cmd.ref_mode = ref_mode_q;
  assign scan_cmd.now      = tick_q;

  llf_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  llf_scan #(
    .MAX_TASKS (MAX_TASKS)
  ) u_llf_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (scan_cmd),
    .count_i    (n_act),
    .ref_idx_i  (ref_q),
    .last_idx_i (last_q),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .res_o      (scan_res),
    .best_idx_o (best_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      task_count_q <= TASK_COUNT_RST;
      tick_q       <= '0;
      last_q       <= '0;
      ref_q        <= '0;
      sel_idx_q    <= '0;
      started_q    <= 1'b0;
      stopped_q    <= 1'b0;
      start_q      <= 1'b0;
      ref_mode_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
      out_q        <= '0;
      sel_rec_q    <= '0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        task_count_q <= cfg_wdata_i;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_i.payload.func == FUNC_LOAD) begin
              res_q   <= idle_res;
              state_q <= S_OUT;
            end else if (stopped_q) begin
              res_q   <= idle_res;
              state_q <= S_OUT;
            end else begin
              start_q    <= 1'b1;
              ref_mode_q <= !started_q;
              state_q    <= started_q ? S_PICK : S_REF;
            end
          end
        end
        S_REF: begin
          if (scan_res.done) begin
            ref_q      <= best_idx;
            last_q     <= best_idx;
            started_q  <= 1'b1;
            start_q    <= 1'b1;
            ref_mode_q <= 1'b0;
            state_q    <= S_PICK;
          end
        end
        S_PICK: begin
          if (scan_res.done) begin
            sel_rec_q <= keep_last ? scan_res.last_rec : scan_res.best_rec;
            sel_idx_q <= keep_last ? last_q : best_idx;
            state_q   <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          res_q   <= upd_res;
          tick_q  <= tick_q + TIME_W'(1);
          last_q  <= sel_idx_q;
          if (stop_now) begin
            stopped_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

@@ sv/llf_chk.sv @@
// Port-level checker for the least-laxity-first scheduler, bound to its top level.
// Depends on llf_pkg for the result item layout.
module llf_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input llf_pkg::out_item_t out_item_i
);
  import llf_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result transfer changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("a second item was taken while one was in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.ran_valid |->
      !out_item_i.job_released && (out_item_i.work_left == '0) &&
      (out_item_i.next_arrival == '0) && (out_item_i.ran_ident == '0) &&
      (out_item_i.ran_slot == '0))
    else $error("a result that ran no task carries task fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.job_released |-> out_item_i.ran_valid && !out_item_i.finished)
    else $error("job released without a run, or after the reference task finished");

endmodule

bind least_laxity_first_scheduler llf_chk u_llf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
